// ----- design/mm4_pkg.sv -----
package mm4_pkg;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned FRAC_W = 16;
  localparam int unsigned PROD_W = 2 * DATA_W;

  typedef struct packed {
    logic valid;
    logic last;
  } mm4_ctl_t;

endpackage

// ----- design/mm4_cell.sv -----
module mm4_cell
  import mm4_pkg::*;
#(
  parameter int unsigned DIM   = 4,
  parameter int unsigned ACC_W = 66
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         wr_left_en,
  input  logic [$clog2(DIM)-1:0]       wr_left_addr,
  input  logic                         wr_right_en,
  input  logic [$clog2(DIM)-1:0]       wr_right_addr,
  input  logic [DATA_W-1:0]            wr_left_data,
  input  logic [DATA_W-1:0]            wr_right_data,
  input  mm4_ctl_t                     in_ctl,
  input  logic [$clog2(DIM)-1:0]       in_row,
  input  logic [$clog2(DIM)-1:0]       in_col,
  input  logic signed [ACC_W-1:0]      in_sum,
  output mm4_ctl_t                     out_ctl,
  output logic [$clog2(DIM)-1:0]       out_row,
  output logic [$clog2(DIM)-1:0]       out_col,
  output logic signed [ACC_W-1:0]      out_sum
);

  localparam int unsigned RW = $clog2(DIM);

  // this cell owns column k of the left matrix and row k of the right one
  logic [DATA_W-1:0] left_mem  [DIM];
  logic [DATA_W-1:0] right_mem [DIM];

  logic [DATA_W-1:0]        rd_left;
  logic [DATA_W-1:0]        rd_right;
  mm4_ctl_t                 a_ctl;
  logic [RW-1:0]            a_row;
  logic [RW-1:0]            a_col;
  logic signed [ACC_W-1:0]  a_sum;
  logic signed [PROD_W-1:0] prod;
  mm4_ctl_t                 b_ctl;
  logic [RW-1:0]            b_row;
  logic [RW-1:0]            b_col;
  logic signed [ACC_W-1:0]  b_sum;

  always_ff @(posedge clk) begin
    if (wr_left_en) begin
      left_mem[wr_left_addr] <= wr_left_data;
    end
    if (wr_right_en) begin
      right_mem[wr_right_addr] <= wr_right_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_ctl   <= '0;
      b_ctl   <= '0;
      out_ctl <= '0;
    end else begin
      a_ctl   <= in_ctl;
      b_ctl   <= a_ctl;
      out_ctl <= b_ctl;
    end
  end

  always_ff @(posedge clk) begin
    rd_left  <= left_mem[in_row];
    rd_right <= right_mem[in_col];
    a_row    <= in_row;
    a_col    <= in_col;
    a_sum    <= in_sum;
    prod     <= $signed(rd_left) * $signed(rd_right);
    b_row    <= a_row;
    b_col    <= a_col;
    b_sum    <= a_sum;
    out_sum  <= b_sum + ACC_W'(prod);
    out_row  <= b_row;
    out_col  <= b_col;
  end

endmodule

// ----- design/matrix_multiply_4x4.sv -----
// An input request is taken while start is high, busy is low and elem_index is
// in range; the request with the last index starts the product, whose elements
// appear one per cycle (MATRIX_DIM^2 in total).
// busy stays high from that request until the last element is on the ports.
// Each product pass runs through a chain of MATRIX_DIM multiply-add cells.
// Reset (rst, synchronous) clears control only; stored elements stay undefined.
module matrix_multiply_4x4
  import mm4_pkg::*;
#(
  parameter int unsigned MATRIX_DIM = 4
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  start,
  output logic                                  busy,
  input  logic signed [DATA_W-1:0]              left_elem,
  input  logic signed [DATA_W-1:0]              right_elem,
  input  logic [$clog2(MATRIX_DIM*MATRIX_DIM)-1:0] elem_index,
  output logic                                  valid,
  output logic signed [DATA_W-1:0]              product_elem,
  output logic [$clog2(MATRIX_DIM*MATRIX_DIM)-1:0] out_index,
  output logic                                  last
);

  localparam int unsigned N     = MATRIX_DIM * MATRIX_DIM;
  localparam int unsigned IW    = $clog2(N);
  localparam int unsigned RW    = $clog2(MATRIX_DIM);
  localparam int unsigned ACC_W = PROD_W + $clog2(MATRIX_DIM);
  localparam int unsigned SH_W  = ACC_W - FRAC_W;

  logic          accept;
  logic          in_range;
  logic [RW-1:0] wr_row;
  logic [RW-1:0] wr_col;

  assign accept   = start && !busy && in_range;
  assign in_range = {1'b0, elem_index} < (IW+1)'(N);

  // split the flat index into row and column without a divider
  always_comb begin
    wr_row = '0;
    for (int r = 1; r < MATRIX_DIM; r++) begin
      if ({1'b0, elem_index} >= (IW+1)'(r * MATRIX_DIM)) begin
        wr_row = RW'(r);
      end
    end
    wr_col = RW'(elem_index - IW'(wr_row * MATRIX_DIM));
  end

  // issue sequencer
  logic          issuing;
  logic [RW-1:0] iss_row;
  logic [RW-1:0] iss_col;
  logic          iss_end;

  assign iss_end = (iss_row == RW'(MATRIX_DIM-1)) && (iss_col == RW'(MATRIX_DIM-1));

  mm4_ctl_t                ctl  [MATRIX_DIM+1];
  logic [RW-1:0]           row  [MATRIX_DIM+1];
  logic [RW-1:0]           col  [MATRIX_DIM+1];
  logic signed [ACC_W-1:0] sum  [MATRIX_DIM+1];

  assign ctl[0].valid = issuing;
  assign ctl[0].last  = iss_end;
  assign row[0]       = iss_row;
  assign col[0]       = iss_col;
  assign sum[0]       = '0;

  for (genvar k = 0; k < MATRIX_DIM; k++) begin : g_cell
    mm4_cell #(
      .DIM   (MATRIX_DIM),
      .ACC_W (ACC_W)
    ) u_cell (
      .clk           (clk),
      .rst           (rst),
      .wr_left_en    (accept && (wr_col == RW'(k))),
      .wr_left_addr  (wr_row),
      .wr_right_en   (accept && (wr_row == RW'(k))),
      .wr_right_addr (wr_col),
      .wr_left_data  (left_elem),
      .wr_right_data (right_elem),
      .in_ctl        (ctl[k]),
      .in_row        (row[k]),
      .in_col        (col[k]),
      .in_sum        (sum[k]),
      .out_ctl       (ctl[k+1]),
      .out_row       (row[k+1]),
      .out_col       (col[k+1]),
      .out_sum       (sum[k+1])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy    <= 1'b0;
      issuing <= 1'b0;
      iss_row <= '0;
      iss_col <= '0;
    end else begin
      if (accept && (elem_index == IW'(N-1))) begin
        busy    <= 1'b1;
        issuing <= 1'b1;
        iss_row <= '0;
        iss_col <= '0;
      end else if (issuing) begin
        if (iss_end) begin
          issuing <= 1'b0;
        end
        if (iss_col == RW'(MATRIX_DIM-1)) begin
          iss_col <= '0;
          iss_row <= iss_row + 1'b1;
        end else begin
          iss_col <= iss_col + 1'b1;
        end
      end
      if (ctl[MATRIX_DIM].valid && ctl[MATRIX_DIM].last) begin
        busy <= 1'b0;
      end
    end
  end

  // shift and saturate
  logic signed [SH_W-1:0]   shifted;
  logic                     fits;
  logic signed [DATA_W-1:0] sat;

  assign shifted = SH_W'(sum[MATRIX_DIM] >>> FRAC_W);
  assign fits    = (&shifted[SH_W-1:DATA_W-1]) || !(|shifted[SH_W-1:DATA_W-1]);

  always_comb begin
    if (fits) begin
      sat = shifted[DATA_W-1:0];
    end else if (shifted[SH_W-1]) begin
      sat = {1'b1, {(DATA_W-1){1'b0}}};
    end else begin
      sat = {1'b0, {(DATA_W-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= ctl[MATRIX_DIM].valid;
    end
  end

  always_ff @(posedge clk) begin
    product_elem <= sat;
    out_index    <= IW'(row[MATRIX_DIM] * MATRIX_DIM) + IW'(col[MATRIX_DIM]);
    last         <= ctl[MATRIX_DIM].last;
  end

endmodule
